>>> rtl/http_request_head_tokenizer_assert.svh
// ----------------------------------------------------------------------------
// HTTP request head tokenizer assertion macros
// Clocked implication checks that are disabled while the active-low reset is low.
// ----------------------------------------------------------------------------
// Each macro takes a label, the clock, the active-low reset and the two sides of the property.
`ifndef HTTP_REQUEST_HEAD_TOKENIZER_ASSERT_SVH
`define HTTP_REQUEST_HEAD_TOKENIZER_ASSERT_SVH

// Same-cycle implication.
`define HTOK_ASSERT_NOW(label, clock, reset_n, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(reset_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define HTOK_ASSERT_NEXT(label, clock, reset_n, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(reset_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/htok_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request head tokenizer package
// Payload types, phase and event codes, and delimiter and letter-range characters.
// ----------------------------------------------------------------------------
`default_nettype none

package htok_pkg;

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_PATH    = 3'd1,
        PH_VERSION = 3'd2,
        PH_NAME    = 3'd3,
        PH_VALUE   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_END   = 2'd1,
        EV_ERROR = 2'd2,
        EV_DONE  = 2'd3
    } event_t;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } htok_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        event_t     event_res;
        phase_t     token_kind;
    } htok_out_t;

endpackage

`default_nettype wire

>>> rtl/htok_stream_if.sv
// ----------------------------------------------------------------------------
// Tokenizer stream interface
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface htok_stream_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/http_request_head_tokenizer.sv
// Output: a result appears in the output register in the cycle after its byte is transferred in.
// Throughput: one byte per cycle; the output register is the only stage and refills while
// its result is being taken, so input ready only drops when a result waits unclaimed.
// Reset: rst_n clears the phase to method, the token flags and the output valid.
// ----------------------------------------------------------------------------
// HTTP request head tokenizer
// Splits a received byte stream into method, path, version and header tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module http_request_head_tokenizer (
    input  wire logic   clk,
    input  wire logic   rst_n,
    htok_stream_if.sink   rx,
    htok_stream_if.source tok
);
    import htok_pkg::*;

    `include "http_request_head_tokenizer_assert.svh"

    phase_t     phase_reg, phase_next;
    logic       cr_seen_reg, cr_seen_next;
    logic       colon_seen_reg, colon_seen_next;
    logic       blank_cr_seen_reg, blank_cr_seen_next;
    logic [1:0] bytes_reg, bytes_next;
    logic       tok_valid_reg;
    htok_out_t  result_reg, result_next;

    logic       accept;
    logic [7:0] c;
    logic       is_sp, is_cr, is_lf, is_colon, is_upper;
    logic [1:0] count;

    assign rx.ready  = !tok_valid_reg || tok.ready;
    assign accept    = rx.valid && rx.ready;
    assign tok.valid = tok_valid_reg;
    assign tok.data  = result_reg;

    assign c        = rx.data.data_byte;
    assign is_sp    = (c == CH_SP);
    assign is_cr    = (c == CH_CR);
    assign is_lf    = (c == CH_LF);
    assign is_colon = (c == CH_COLON);
    assign is_upper = (c >= CH_A) && (c <= CH_Z);
    assign count    = (bytes_reg == 2'd3) ? 2'd3 : bytes_reg + 2'd1;

    // Next phase and token flags.
    always_comb
    begin
        phase_next         = phase_reg;
        cr_seen_next       = cr_seen_reg;
        colon_seen_next    = colon_seen_reg;
        blank_cr_seen_next = blank_cr_seen_reg;
        bytes_next         = count;
        if (rx.data.stream_end)
        begin
            cr_seen_next       = 1'b0;
            colon_seen_next    = 1'b0;
            blank_cr_seen_next = 1'b0;
            bytes_next         = 2'd0;
        end
        else
        begin
            unique case (phase_reg)
                PH_PATH:
                begin
                    if (is_sp)
                    begin
                        phase_next = PH_VERSION;
                        bytes_next = 2'd0;
                    end
                end
                PH_VERSION, PH_VALUE:
                begin
                    priority if (is_cr)
                    begin
                        cr_seen_next = 1'b1;
                    end
                    else if (is_lf)
                    begin
                        if (cr_seen_reg)
                        begin
                            phase_next = PH_NAME;
                        end
                        cr_seen_next = 1'b0;
                        bytes_next   = 2'd0;
                    end
                    else
                    begin
                        cr_seen_next = 1'b0;
                    end
                end
                PH_NAME:
                begin
                    priority if (is_cr)
                    begin
                        if (count == 2'd1)
                        begin
                            blank_cr_seen_next = 1'b1;
                        end
                    end
                    else if (is_lf)
                    begin
                        // A CR LF pair at the start of a name closes the header section.
                        if (count == 2'd2 && blank_cr_seen_reg)
                        begin
                            colon_seen_next    = 1'b0;
                            blank_cr_seen_next = 1'b0;
                            bytes_next         = 2'd0;
                        end
                    end
                    else if (is_colon)
                    begin
                        colon_seen_next = 1'b1;
                    end
                    else if (is_sp)
                    begin
                        if (colon_seen_reg)
                        begin
                            phase_next = PH_VALUE;
                        end
                        colon_seen_next    = 1'b0;
                        blank_cr_seen_next = 1'b0;
                        bytes_next         = 2'd0;
                    end
                    else
                    begin
                        colon_seen_next = 1'b0;
                    end
                end
                default:
                begin
                    // Method phase; unused phase codes behave the same way.
                    if (is_sp)
                    begin
                        phase_next = PH_PATH;
                    end
                    if (!is_upper)
                    begin
                        cr_seen_next       = 1'b0;
                        colon_seen_next    = 1'b0;
                        blank_cr_seen_next = 1'b0;
                        bytes_next         = 2'd0;
                    end
                end
            endcase
        end
    end

    // Result for the byte in hand.
    always_comb
    begin
        result_next.out_byte   = 8'h00;
        result_next.out_valid  = 1'b0;
        result_next.event_res  = EV_NONE;
        result_next.token_kind = PH_METHOD;
        if (rx.data.stream_end)
        begin
            result_next.event_res = EV_ERROR;
        end
        else
        begin
            unique case (phase_reg)
                PH_PATH:
                begin
                    if (is_sp)
                    begin
                        result_next.event_res  = EV_END;
                        result_next.token_kind = PH_PATH;
                    end
                    else
                    begin
                        result_next.out_byte  = c;
                        result_next.out_valid = 1'b1;
                    end
                end
                PH_VERSION, PH_VALUE:
                begin
                    priority if (is_cr)
                    begin
                        result_next.event_res = EV_NONE;
                    end
                    else if (is_lf)
                    begin
                        if (cr_seen_reg)
                        begin
                            result_next.event_res  = EV_END;
                            result_next.token_kind = phase_reg;
                        end
                        else
                        begin
                            result_next.event_res = EV_ERROR;
                        end
                    end
                    else
                    begin
                        result_next.out_byte  = c;
                        result_next.out_valid = 1'b1;
                    end
                end
                PH_NAME:
                begin
                    priority if (is_cr || is_colon)
                    begin
                        result_next.event_res = EV_NONE;
                    end
                    else if (is_lf)
                    begin
                        if (count == 2'd2 && blank_cr_seen_reg)
                        begin
                            result_next.event_res = EV_DONE;
                        end
                    end
                    else if (is_sp)
                    begin
                        if (colon_seen_reg)
                        begin
                            result_next.event_res  = EV_END;
                            result_next.token_kind = PH_NAME;
                        end
                        else
                        begin
                            result_next.event_res = EV_ERROR;
                        end
                    end
                    else
                    begin
                        result_next.out_byte  = c;
                        result_next.out_valid = 1'b1;
                    end
                end
                default:
                begin
                    priority if (is_sp)
                    begin
                        result_next.event_res  = EV_END;
                        result_next.token_kind = PH_METHOD;
                    end
                    else if (is_upper)
                    begin
                        result_next.out_byte  = c;
                        result_next.out_valid = 1'b1;
                    end
                    else
                    begin
                        result_next.event_res = EV_ERROR;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_METHOD;
            cr_seen_reg       <= 1'b0;
            colon_seen_reg    <= 1'b0;
            blank_cr_seen_reg <= 1'b0;
            bytes_reg         <= 2'd0;
            tok_valid_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg         <= phase_next;
                cr_seen_reg       <= cr_seen_next;
                colon_seen_reg    <= colon_seen_next;
                blank_cr_seen_reg <= blank_cr_seen_next;
                bytes_reg         <= bytes_next;
                tok_valid_reg     <= 1'b1;
            end
            else if (tok.ready)
            begin
                tok_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    // Every transfer in leaves a result waiting in the next cycle.
    `HTOK_ASSERT_NEXT(a_accept_fills, clk, rst_n, accept, tok_valid_reg)

    // A stream end always reports an error.
    `HTOK_ASSERT_NEXT(a_stream_end_error, clk, rst_n, accept && rx.data.stream_end,
        result_reg.event_res == EV_ERROR && !result_reg.out_valid)

    // A passed byte never carries an event.
    `HTOK_ASSERT_NOW(a_byte_no_event, clk, rst_n, tok_valid_reg && result_reg.out_valid,
        result_reg.event_res == EV_NONE)

    // A space ending the method moves the tokenizer to the path.
    `HTOK_ASSERT_NEXT(a_method_to_path, clk, rst_n,
        accept && !rx.data.stream_end && phase_reg == PH_METHOD && is_sp,
        phase_reg == PH_PATH && result_reg.event_res == EV_END)

endmodule

`default_nettype wire
